// ===== rtl/core/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the Q24.8 fixed-point ALU: item structs,
// mode codes and the sideband that travels beside the divider pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Default number of fraction bits.
  localparam int FRACTION_BITS_DEF = 8;

  // Mode codes.
  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_LT       = 4'd4;
  localparam logic [3:0] MODE_LE       = 4'd5;
  localparam logic [3:0] MODE_GT       = 4'd6;
  localparam logic [3:0] MODE_GE       = 4'd7;
  localparam logic [3:0] MODE_EQ       = 4'd8;
  localparam logic [3:0] MODE_NE       = 4'd9;
  localparam logic [3:0] MODE_MAX      = 4'd10;
  localparam logic [3:0] MODE_MIN      = 4'd11;
  localparam logic [3:0] MODE_INC      = 4'd12;
  localparam logic [3:0] MODE_DEC      = 4'd13;
  localparam logic [3:0] MODE_FROM_INT = 4'd14;
  localparam logic [3:0] MODE_TO_INT   = 4'd15;

  // One input item.
  typedef struct packed {
    logic        [3:0]  mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

  // Everything an item needs beside the quotient while it crosses the divider.
  typedef struct packed {
    logic [3:0]  mode;
    logic        neg;
    logic        div_zero;
    logic [31:0] simple;
    logic        cmp;
    logic [31:0] prod;
  } side_t;

endpackage

// ===== rtl/core/fpa_div_pipe.sv =====
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Pipelined restoring divider on magnitudes: one quotient bit per stage,
// (dividend << FRACTION_BITS) / divisor, low 32 quotient bits kept. A
// sideband struct rides along so the item leaves in order with its data.
// ----------------------------------------------------------------------------
module fpa_div_pipe #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   dividend,
  input  logic [31:0]   divisor,
  input  fpa_pkg::side_t side_in,
  output logic          out_valid,
  output logic [31:0]   quotient,
  output fpa_pkg::side_t side_out
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRACTION_BITS;

  logic          vld   [NW];
  logic [31:0]   rem   [NW];
  logic [31:0]   quo   [NW];
  logic [NW-1:0] num   [NW];
  logic [31:0]   dvs   [NW];
  side_t         side  [NW];

  genvar i;
  generate
    for (i = 0; i < NW; i++) begin : g_stage
      logic          prev_vld;
      logic [31:0]   prev_rem;
      logic [31:0]   prev_quo;
      logic [NW-1:0] prev_num;
      logic [31:0]   prev_dvs;
      side_t         prev_side;
      logic [32:0]   trial;
      logic [33:0]   diff;
      logic          fits;

      // Stage inputs: the ports for the first stage, the prior stage otherwise.
      if (i == 0) begin : g_first
        always_comb begin
          prev_vld  = in_valid;
          prev_rem  = '0;
          prev_quo  = '0;
          prev_num  = {dividend, {FRACTION_BITS{1'b0}}};
          prev_dvs  = divisor;
          prev_side = side_in;
        end
      end else begin : g_next
        always_comb begin
          prev_vld  = vld[i-1];
          prev_rem  = rem[i-1];
          prev_quo  = quo[i-1];
          prev_num  = num[i-1];
          prev_dvs  = dvs[i-1];
          prev_side = side[i-1];
        end
      end

      // Bring down one dividend bit and try a subtract.
      always_comb begin
        trial = {prev_rem, prev_num[NW-1]};
        diff  = {1'b0, trial} - {2'b00, prev_dvs};
        fits  = !diff[33];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else begin
          vld[i] <= prev_vld;
        end
      end

      always_ff @(posedge clk) begin
        rem[i]  <= fits ? diff[31:0] : trial[31:0];
        quo[i]  <= {prev_quo[30:0], fits};
        num[i]  <= {prev_num[NW-2:0], 1'b0};
        dvs[i]  <= prev_dvs;
        side[i] <= prev_side;
      end
    end
  endgenerate

  assign out_valid = vld[NW-1];
  assign quotient  = quo[NW-1];
  assign side_out  = side[NW-1];

endmodule

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits: add, sub,
// mul, div, compares, max/min, inc/dec and integer conversions.
//
//   channel   ports              timing
//   -------   ----------------   ---------------------------------------
//   request   start, request     taken when start is high and busy low
//   result    done, result       one cycle, done marks it, no back-pressure
//
// One item may enter every cycle; busy is always low. Every item, whatever
// its mode (Q24.8 by default), passes the input and magnitude registers, the
// divider (one quotient bit per stage) and the result register. Results
// leave in the order items entered. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fpa_pkg::req_t request,
  output logic          done,
  output fpa_pkg::rsp_t result
);
  import fpa_pkg::*;

  // Stage 1: input register.
  logic  v1;
  req_t  req_q;

  // Stage 2: magnitudes and the simple (non-multiply, non-divide) results.
  logic        v2;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  side_t       side2;

  logic [31:0] a1, b1, ma1, mb1, simple1, shr1;
  logic        cmp1, lt_ab, lt_ba;
  logic [63:0] prod_full;
  side_t       side_div;

  logic        dv_valid;
  logic [31:0] dv_quo;
  side_t       dv_side;
  logic [31:0] res_next;

  // The pipeline never holds items off.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req_q <= request;
  end

  // Magnitudes, compares and the simple results.
  always_comb begin
    a1    = req_q.operand_a;
    b1    = req_q.operand_b;
    ma1   = a1[31] ? (32'd0 - a1) : a1;
    mb1   = b1[31] ? (32'd0 - b1) : b1;
    lt_ab = $signed(a1) < $signed(b1);
    lt_ba = $signed(b1) < $signed(a1);
    shr1  = ma1 >> FRACTION_BITS;
    simple1 = '0;
    cmp1    = 1'b0;
    case (req_q.mode)
      MODE_ADD:      simple1 = a1 + b1;
      MODE_SUB:      simple1 = a1 - b1;
      MODE_LT:       cmp1 = lt_ab;
      MODE_LE:       cmp1 = !lt_ba;
      MODE_GT:       cmp1 = lt_ba;
      MODE_GE:       cmp1 = !lt_ab;
      MODE_EQ:       cmp1 = (a1 == b1);
      MODE_NE:       cmp1 = (a1 != b1);
      MODE_MAX:      simple1 = lt_ba ? a1 : b1;
      MODE_MIN:      simple1 = lt_ab ? a1 : b1;
      MODE_INC:      simple1 = a1 + 32'd1;
      MODE_DEC:      simple1 = a1 - 32'd1;
      MODE_FROM_INT: simple1 = a1 << FRACTION_BITS;
      MODE_TO_INT:   simple1 = a1[31] ? (32'd0 - shr1) : shr1;
      default:       simple1 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mag_a          <= ma1;
    mag_b          <= mb1;
    side2.mode     <= req_q.mode;
    side2.neg      <= a1[31] ^ b1[31];
    side2.div_zero <= (b1 == 32'd0);
    side2.simple   <= simple1;
    side2.cmp      <= cmp1;
    side2.prod     <= '0;
  end

  // Product of magnitudes, registered in the first divider stage.
  always_comb begin
    prod_full     = mag_a * mag_b;
    side_div      = side2;
    side_div.prod = prod_full[FRACTION_BITS +: 32];
  end

  fpa_div_pipe #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .dividend (mag_a),
    .divisor  (mag_b),
    .side_in  (side_div),
    .out_valid(dv_valid),
    .quotient (dv_quo),
    .side_out (dv_side)
  );

  // Final select and sign fix-up.
  always_comb begin
    case (dv_side.mode)
      MODE_MUL: res_next = dv_side.neg ? (32'd0 - dv_side.prod) : dv_side.prod;
      MODE_DIV: begin
        if (dv_side.div_zero) begin
          res_next = '0;
        end else begin
          res_next = dv_side.neg ? (32'd0 - dv_quo) : dv_quo;
        end
      end
      default:  res_next = dv_side.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.result_value   <= res_next;
    result.compare_true   <= dv_side.cmp;
    result.divide_by_zero <= (dv_side.mode == MODE_DIV) && dv_side.div_zero;
  end

endmodule
